// ===== hw/rtl/pooled_linked_list_engine_top_assert.svh =====
// assertion macros for the list engine
`ifndef POOLED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define POOLED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// a condition implies another in the same cycle
`define PLL_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// a condition implies another in the next cycle
`define PLL_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hw/rtl/pll_pkg.sv =====
// ----------------------------------------------------------------------------
// pll_pkg
// Types and command codes shared by the list engine modules.
// ----------------------------------------------------------------------------
package pll_pkg;

   localparam int unsigned ActionWidth = 4;
   localparam int unsigned StatusWidth = 3;

   typedef enum logic [ActionWidth-1:0] {
      ACT_PUSH_FRONT = 4'd0,
      ACT_PUSH_BACK  = 4'd1,
      ACT_INS_BEFORE = 4'd2,
      ACT_INS_AFTER  = 4'd3,
      ACT_REMOVE     = 4'd4,
      ACT_MV_BEFORE  = 4'd5,
      ACT_MV_AFTER   = 4'd6,
      ACT_POP_FRONT  = 4'd7,
      ACT_POP_BACK   = 4'd8,
      ACT_PEEK_FRONT = 4'd9,
      ACT_PEEK_BACK  = 4'd10
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_SAME      = 3'd4
   } status_type;

   // input word
   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [5:0]             node;
      logic [5:0]             target;
      logic [31:0]            payload;
      logic                   write_payload;
   } req_type;

   // result word
   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [5:0]             result_node;
      logic [31:0]            result_data;
      logic [6:0]             entries;
   } rsp_type;

   // link memory write port
   typedef struct packed {
      logic       wr_next;
      logic       wr_prev;
      logic [5:0] addr;
      logic [6:0] next_val;
      logic [6:0] prev_val;
   } link_wr_type;

endpackage

// ===== hw/rtl/pll_link_mem.sv =====
// ----------------------------------------------------------------------------
// pll_link_mem
// Next and previous link memory, one read and one write port, read data
// registered.
// ----------------------------------------------------------------------------
module pll_link_mem (
   input  logic                clock,
   input  pll_pkg::link_wr_type wr,
   input  logic [5:0]          rd_addr,
   output logic [6:0]          rd_next,
   output logic [6:0]          rd_prev
);

   logic [6:0] next_mem [64];
   logic [6:0] prev_mem [64];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.wr_next) begin
         next_mem[wr.addr] <= wr.next_val;
      end
      if (wr.wr_prev) begin
         prev_mem[wr.addr] <= wr.prev_val;
      end
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/pll_data_mem.sv =====
// ----------------------------------------------------------------------------
// pll_data_mem
// Node data word memory, one read and one write port, read data registered.
// ----------------------------------------------------------------------------
module pll_data_mem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [5:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [64];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/pooled_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_top
// Doubly linked list over a fixed pool of 64 nodes with a free-node stack.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle under rsp_valid, and the receiver cannot
// stall it. Busy is already low in the cycle of the result word, so the
// next command can be taken at its end. An error or an unknown action goes
// from the first check straight to the result word without writing the
// memories. The sequencer works through the single read and write port of
// the link memory: it reads the named node, which gives its neighbors, and
// then the target, and then writes the changed links one a cycle. A move is
// the longest command. Nodes freed last are reused first.
// ----------------------------------------------------------------------------
`include "pooled_linked_list_engine_top_assert.svh"

module pooled_linked_list_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pll_pkg::req_type req_word,
   output logic             rsp_valid,
   output pll_pkg::rsp_type rsp_word
);

   localparam logic [6:0] Nil = 7'd64;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_A, S_LAT_A, S_RD_B, S_LAT_B, S_DECIDE,
      S_W1, S_W2, S_W3, S_W4, S_W5, S_DATA, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   pll_pkg::req_type  req_ff, req_in;
   logic [63:0]       in_use_ff, in_use_in;
   logic [6:0]        head_ff, head_in, tail_ff, tail_in;
   logic [6:0]        free_ff, free_in, fresh_ff, fresh_in;
   logic [6:0]        count_ff, count_in;
   // node under work, its neighbors, target and target neighbor
   logic [6:0]        n_ff, n_in, np_ff, np_in, nx_ff, nx_in;
   logic [6:0]        t_ff, t_in, tn_ff, tn_in;
   logic [2:0]        st_ff, st_in;
   logic              res_ff, res_in;
   logic              valid_ff, valid_in;

   pll_pkg::link_wr_type wr;
   logic [5:0]        rd_addr;
   logic [6:0]        rd_next, rd_prev;
   logic              dwr;
   logic [5:0]        drd_addr;
   logic [31:0]       rd_data;

   pll_link_mem u_link (
      .clock(clock), .wr(wr), .rd_addr(rd_addr),
      .rd_next(rd_next), .rd_prev(rd_prev)
   );

   pll_data_mem u_data (
      .clock(clock), .wr_en(dwr), .wr_addr(n_ff[5:0]), .wr_data(req_ff.payload),
      .rd_addr(drd_addr), .rd_data(rd_data)
   );

   logic is_ins, is_mv, is_before;
   logic node_listed, tgt_listed;
   assign is_ins      = req_ff.action <= pll_pkg::ACT_INS_AFTER;
   assign is_mv       = (req_ff.action == pll_pkg::ACT_MV_BEFORE) ||
                        (req_ff.action == pll_pkg::ACT_MV_AFTER);
   assign is_before   = (req_ff.action == pll_pkg::ACT_PUSH_FRONT) ||
                        (req_ff.action == pll_pkg::ACT_INS_BEFORE) ||
                        (req_ff.action == pll_pkg::ACT_MV_BEFORE);
   assign node_listed = in_use_ff[req_ff.node];
   assign tgt_listed  = in_use_ff[req_ff.target];

   // link write helper values
   function automatic pll_pkg::link_wr_type lw(input logic wn, input logic wp,
                                               input logic [6:0] a,
                                               input logic [6:0] nv,
                                               input logic [6:0] pv);
      pll_pkg::link_wr_type w;
      w.wr_next  = wn & ~a[6];
      w.wr_prev  = wp & ~a[6];
      w.addr     = a[5:0];
      w.next_val = nv;
      w.prev_val = pv;
      return w;
   endfunction

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      in_use_in = in_use_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      fresh_in  = fresh_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      np_in     = np_ff;
      nx_in     = nx_ff;
      t_in      = t_ff;
      tn_in     = tn_ff;
      st_in     = st_ff;
      res_in    = res_ff;
      valid_in  = 1'b0;
      wr        = lw(1'b0, 1'b0, Nil, Nil, Nil);
      rd_addr   = n_ff[5:0];
      dwr       = 1'b0;
      drd_addr  = n_ff[5:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               st_in    = pll_pkg::ST_OK;
               res_in   = 1'b0;
               state_in = S_RD_A;
            end
         end
         // pick the first node to read and check errors
         S_RD_A: begin
            state_in = S_LAT_A;
            if (is_ins) begin
               // ref node into t, new node into n
               if (req_ff.action == pll_pkg::ACT_PUSH_FRONT) t_in = head_ff;
               else if (req_ff.action == pll_pkg::ACT_PUSH_BACK) t_in = tail_ff;
               else if (count_ff == 7'd0) t_in = Nil;
               else if (node_listed) t_in = {1'b0, req_ff.node};
               else begin
                  st_in = pll_pkg::ST_NOT_FOUND; state_in = S_DONE;
               end
               if (state_in != S_DONE) begin
                  if (!free_ff[6]) n_in = free_ff;
                  else if (!fresh_ff[6]) n_in = fresh_ff;
                  else begin
                     st_in = pll_pkg::ST_FULL; state_in = S_DONE;
                  end
               end
            end else if (req_ff.action <= pll_pkg::ACT_PEEK_BACK) begin
               if (count_ff == 7'd0) begin
                  st_in = pll_pkg::ST_EMPTY; state_in = S_DONE;
               end else if (req_ff.action >= pll_pkg::ACT_POP_FRONT) begin
                  n_in = ((req_ff.action == pll_pkg::ACT_POP_FRONT) ||
                          (req_ff.action == pll_pkg::ACT_PEEK_FRONT)) ? head_ff : tail_ff;
                  if (n_in[6] || !in_use_ff[n_in[5:0]]) begin
                     st_in = pll_pkg::ST_EMPTY; state_in = S_DONE;
                  end
               end else if (!node_listed || (is_mv && !tgt_listed)) begin
                  st_in = pll_pkg::ST_NOT_FOUND; state_in = S_DONE;
               end else if (is_mv && req_ff.node == req_ff.target) begin
                  st_in = pll_pkg::ST_SAME; state_in = S_DONE;
               end else begin
                  n_in = {1'b0, req_ff.node};
                  t_in = {1'b0, req_ff.target};
               end
            end else begin
               state_in = S_DONE;
            end
            rd_addr = n_in[5:0];
         end
         // links of n now on the read port
         S_LAT_A: begin
            np_in    = rd_prev;
            nx_in    = rd_next;
            res_in   = 1'b1;
            state_in = S_RD_B;
            if (is_ins) begin
               // pop the free stack
               if (!free_ff[6] && n_ff == free_ff) begin
                  free_in = (rd_next > Nil) ? Nil : rd_next;
               end else begin
                  fresh_in = fresh_ff + 7'd1;
               end
            end else if (!is_mv) begin
               state_in = S_DECIDE;
            end
         end
         // read links of the reference node
         S_RD_B: begin
            rd_addr  = t_ff[5:0];
            state_in = S_LAT_B;
         end
         S_LAT_B: begin
            if (is_mv) begin
               // target links as seen after unlinking n
               if (is_before) tn_in = (rd_prev == n_ff) ? np_ff : rd_prev;
               else tn_in = (rd_next == n_ff) ? nx_ff : rd_next;
            end else begin
               tn_in = is_before ? rd_prev : rd_next;
            end
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_W1;
         end
         // unlink step for remove, pop and move
         S_W1: begin
            state_in = S_W3;
            if (is_ins || req_ff.action >= pll_pkg::ACT_PEEK_FRONT) begin
               state_in = is_ins ? S_W3 : S_DATA;
            end else begin
               wr = lw(1'b1, 1'b0, np_ff, nx_ff, Nil);
               if (np_ff[6]) head_in = nx_ff;
               state_in = S_W2;
            end
         end
         S_W2: begin
            wr = lw(1'b0, 1'b1, nx_ff, Nil, np_ff);
            if (nx_ff[6]) tail_in = np_ff;
            in_use_in[n_ff[5:0]] = 1'b0;
            count_in = count_ff - 7'd1;
            if (is_mv) begin
               state_in = S_W3;
            end else begin
               state_in = S_W5;
            end
         end
         // link n next to t
         S_W3: begin
            if (t_ff[6]) begin
               wr = lw(1'b1, 1'b1, n_ff, Nil, Nil);
               head_in = n_ff;
               tail_in = n_ff;
               state_in = S_DATA;
            end else if (is_before) begin
               wr = lw(1'b1, 1'b1, n_ff, t_ff, tn_ff);
               state_in = S_W4;
            end else begin
               wr = lw(1'b1, 1'b1, n_ff, tn_ff, t_ff);
               state_in = S_W4;
            end
            in_use_in[n_ff[5:0]] = 1'b1;
            count_in = count_in + 7'd1;
         end
         S_W4: begin
            if (is_before) begin
               wr = lw(1'b0, 1'b1, t_ff, Nil, n_ff);
               np_in = tn_ff;
            end else begin
               wr = lw(1'b1, 1'b0, t_ff, n_ff, Nil);
            end
            state_in = S_W5;
         end
         S_W5: begin
            state_in = S_DATA;
            if (is_mv || is_ins) begin
               // neighbor on the far side of t
               if (is_before) begin
                  wr = lw(1'b1, 1'b0, tn_ff, n_ff, Nil);
                  if (tn_ff[6]) head_in = n_ff;
               end else begin
                  wr = lw(1'b0, 1'b1, tn_ff, Nil, n_ff);
                  if (tn_ff[6]) tail_in = n_ff;
               end
            end else begin
               // push freed node on the stack
               wr = lw(1'b1, 1'b1, n_ff, free_ff, Nil);
               free_in = n_ff;
            end
         end
         S_DATA: begin
            dwr      = is_ins && req_ff.write_payload;
            state_in = S_DONE;
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         in_use_ff <= '0;
         head_ff   <= Nil;
         tail_ff   <= Nil;
         free_ff   <= Nil;
         fresh_ff  <= 7'd0;
         count_ff  <= 7'd0;
         valid_ff  <= 1'b0;
         res_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         free_ff   <= free_in;
         fresh_ff  <= fresh_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
         res_ff    <= res_in;
      end
      req_ff <= req_in;
      n_ff   <= n_in;
      np_ff  <= np_in;
      nx_ff  <= nx_in;
      t_ff   <= t_in;
      tn_ff  <= tn_in;
      st_ff  <= st_in;
   end

   // result word; data word read at the end of S_DONE, after the S_DATA write
   logic [5:0]  out_node_ff;
   logic [31:0] out_data_ff;
   logic        out_res_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         out_res_ff  <= res_ff && (st_ff == pll_pkg::ST_OK);
         out_node_ff <= n_ff[5:0];
      end
   end
   assign out_data_ff = rd_data;

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_valid             = valid_ff;
   assign rsp_word.status       = st_ff;
   assign rsp_word.result_node  = out_res_ff ? out_node_ff : 6'd0;
   assign rsp_word.result_data  = out_res_ff ? out_data_ff : 32'd0;
   assign rsp_word.entries      = count_ff;

   `PLL_ASSERT_IMPLY(a_count_max, clock, reset, 1'b1, count_ff <= Nil, "count beyond pool")
   `PLL_ASSERT_NEXT(a_one_rsp, clock, reset, rsp_valid, !rsp_valid, "result word repeated")
   `PLL_ASSERT_IMPLY(a_busy_rsp, clock, reset, state_ff == S_DONE, busy, "done while not busy")
   `PLL_ASSERT_NEXT(a_take, clock, reset, start && !busy, busy, "command not taken")

endmodule

// ===== tb/pooled_linked_list_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_top_tb
// Self-checking bench for the pooled doubly linked list engine.
// ----------------------------------------------------------------------------
// Commands are queued by an initial block and driven with random gaps. A
// shadow copy of the pool tracks links, free stack and fresh counter, works out
// each result word when a command is taken, and the monitor compares every
// result word with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine_top_tb;

   localparam int NIL = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   pll_pkg::req_type req_word = '0;
   logic             rsp_valid;
   pll_pkg::rsp_type rsp_word;

   pooled_linked_list_engine_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow pool
   int          sh_next [NIL];
   int          sh_prev [NIL];
   logic [31:0] sh_data [NIL];
   bit          sh_used [NIL];
   bit          sh_written [NIL];
   int          sh_head = NIL, sh_tail = NIL, sh_free = NIL;
   int          sh_fresh = 0, sh_count = 0;

   pll_pkg::req_type pending_cmds[$];
   pll_pkg::rsp_type expected_rsps[$];
   int      n_errors = 0;
   int      n_sent = 0, n_checked = 0;
   int      stat_seen [8];
   bit      hold_sender = 0;
   int      idle_cycles = 0;
   bit      busy_at_edge = 1'b0;

   function automatic bit is_listed(int n);
      return n < NIL && sh_used[n];
   endfunction

   function automatic void set_nxt(int n, int v);
      if (n < NIL) sh_next[n] = v; else sh_head = v;
   endfunction

   function automatic void set_prv(int n, int v);
      if (n < NIL) sh_prev[n] = v; else sh_tail = v;
   endfunction

   function automatic void unlink(int n);
      set_nxt(sh_prev[n], sh_next[n]);
      set_prv(sh_next[n], sh_prev[n]);
      sh_used[n] = 0;
      sh_count--;
   endfunction

   function automatic void link_in(int n, int ref_n, bit after);
      int p, x;
      if (ref_n >= NIL) begin
         sh_next[n] = NIL; sh_prev[n] = NIL; sh_head = n; sh_tail = n;
      end else if (!after) begin
         p = sh_prev[ref_n];
         sh_prev[n] = p; sh_next[n] = ref_n; set_nxt(p, n); sh_prev[ref_n] = n;
      end else begin
         x = sh_next[ref_n];
         sh_next[n] = x; sh_prev[n] = ref_n; sh_next[ref_n] = n; set_prv(x, n);
      end
      sh_used[n] = 1;
      sh_count++;
   endfunction

   function automatic void free_node(int n);
      unlink(n);
      sh_prev[n] = NIL;
      sh_next[n] = sh_free;
      sh_free = n;
   endfunction

   // node the next allocation would take, NIL when the pool is exhausted
   function automatic int next_alloc();
      if (sh_free < NIL) return sh_free;
      if (sh_fresh < NIL) return sh_fresh;
      return NIL;
   endfunction

   // predicted result of one list command, shadow pool updated
   function automatic pll_pkg::rsp_type list_command(pll_pkg::req_type c);
      pll_pkg::rsp_type r;
      int st, res, ref_n, n;
      st = pll_pkg::ST_OK; res = NIL; ref_n = NIL;
      if (c.action <= pll_pkg::ACT_INS_AFTER) begin
         if (c.action == pll_pkg::ACT_PUSH_FRONT) ref_n = sh_head;
         else if (c.action == pll_pkg::ACT_PUSH_BACK) ref_n = sh_tail;
         else if (sh_count != 0) begin
            if (is_listed(c.node)) ref_n = c.node; else st = pll_pkg::ST_NOT_FOUND;
         end
         if (st == pll_pkg::ST_OK) begin
            n = next_alloc();
            if (n >= NIL) st = pll_pkg::ST_FULL;
            else begin
               if (sh_free < NIL) sh_free = sh_next[n];
               else sh_fresh++;
               link_in(n, ref_n, c.action == pll_pkg::ACT_PUSH_BACK ||
                                 c.action == pll_pkg::ACT_INS_AFTER);
               if (c.write_payload) begin
                  sh_data[n] = c.payload; sh_written[n] = 1;
               end
               res = n;
            end
         end
      end else if (c.action <= pll_pkg::ACT_PEEK_BACK) begin
         if (sh_count == 0) st = pll_pkg::ST_EMPTY;
         else if (c.action == pll_pkg::ACT_REMOVE) begin
            if (is_listed(c.node)) begin res = c.node; free_node(c.node); end
            else st = pll_pkg::ST_NOT_FOUND;
         end else if (c.action == pll_pkg::ACT_MV_BEFORE ||
                      c.action == pll_pkg::ACT_MV_AFTER) begin
            if (!is_listed(c.node) || !is_listed(c.target)) st = pll_pkg::ST_NOT_FOUND;
            else if (c.node == c.target) st = pll_pkg::ST_SAME;
            else begin
               unlink(c.node);
               link_in(c.node, c.target, c.action == pll_pkg::ACT_MV_AFTER);
               res = c.node;
            end
         end else begin
            n = (c.action == pll_pkg::ACT_POP_FRONT ||
                 c.action == pll_pkg::ACT_PEEK_FRONT) ? sh_head : sh_tail;
            if (!is_listed(n)) st = pll_pkg::ST_EMPTY;
            else begin
               res = n;
               if (c.action <= pll_pkg::ACT_POP_BACK) free_node(n);
            end
         end
      end
      r.status = st[2:0];
      r.result_node = (res < NIL) ? res[5:0] : 6'd0;
      r.result_data = (res < NIL) ? sh_data[res] : 32'd0;
      r.entries = sh_count[6:0];
      return r;
   endfunction

   // random listed node, or any node when the list is empty
   function automatic logic [5:0] pick_listed();
      int k, n;
      if (sh_count == 0) return 6'($urandom_range(63));
      k = $urandom_range(sh_count - 1);
      n = sh_head;
      repeat (k) n = sh_next[n];
      return n[5:0];
   endfunction

   // planning copy: queue is filled ahead, so plan against a replica
   int          pl_next [NIL], pl_prev [NIL];
   logic [31:0] pl_data [NIL];
   bit          pl_used [NIL], pl_written [NIL];
   int          pl_head, pl_tail, pl_free, pl_fresh, pl_count;

   task automatic save_shadow();
      pl_next = sh_next; pl_prev = sh_prev; pl_data = sh_data; pl_used = sh_used;
      pl_written = sh_written; pl_head = sh_head; pl_tail = sh_tail;
      pl_free = sh_free; pl_fresh = sh_fresh; pl_count = sh_count;
   endtask

   task automatic restore_shadow();
      sh_next = pl_next; sh_prev = pl_prev; sh_data = pl_data; sh_used = pl_used;
      sh_written = pl_written; sh_head = pl_head; sh_tail = pl_tail;
      sh_free = pl_free; sh_fresh = pl_fresh; sh_count = pl_count;
   endtask

   pll_pkg::rsp_type plan_dummy;

   // queue one command; a write_payload of 0 onto a never-written node is
   // turned into a write so no undefined word is ever read back
   task automatic plan(logic [3:0] act, logic [5:0] nd, logic [5:0] tg,
                       logic [31:0] pay, logic wr);
      pll_pkg::req_type c;
      int n;
      c.action = act; c.node = nd; c.target = tg; c.payload = pay;
      c.write_payload = wr;
      if (act <= pll_pkg::ACT_INS_AFTER && !wr) begin
         n = next_alloc();
         if (n < NIL && !sh_written[n]) c.write_payload = 1'b1;
      end
      pending_cmds.push_back(c);
      plan_dummy = list_command(c);
   endtask

   task automatic plan_random(int mode);
      int r;
      logic [3:0] act;
      r = $urandom_range(99);
      if (mode == 0) begin
         // grow bias
         if (r < 45) act = 4'($urandom_range(3));
         else if (r < 95) act = 4'($urandom_range(4, 10));
         else act = 4'($urandom_range(11, 15));
      end else begin
         // shrink bias
         if (r < 20) act = 4'($urandom_range(3));
         else if (r < 97) act = 4'($urandom_range(4, 10));
         else act = 4'($urandom_range(11, 15));
      end
      plan(act,
           ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : pick_listed(),
           ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : pick_listed(),
           $urandom, 1'($urandom_range(3) != 0));
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver; a word still offered while busy stays put
   int gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (start && busy_at_edge) begin
            // keep waiting for the engine
         end else if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
         end else if (pending_cmds.size() > 0 && !hold_sender) begin
            req_word <= pending_cmds.pop_front();
            start <= 1'b1;
            gap <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // acceptance and result checking at the rising edge
   always @(posedge clock) begin
      pll_pkg::rsp_type exp_w;
      busy_at_edge <= busy;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(list_command(req_word));
            n_sent++;
         end
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result word with nothing expected");
               n_errors++;
            end else begin
               exp_w = expected_rsps.pop_front();
               n_checked++;
               stat_seen[rsp_word.status]++;
               if (rsp_word.status !== exp_w.status) begin
                  $error("status: expected %0d, actual %0d", exp_w.status, rsp_word.status);
                  n_errors++;
               end
               if (rsp_word.result_node !== exp_w.result_node) begin
                  $error("result_node: expected %0d, actual %0d",
                         exp_w.result_node, rsp_word.result_node);
                  n_errors++;
               end
               if (rsp_word.result_data !== exp_w.result_data) begin
                  $error("result_data: expected %h, actual %h",
                         exp_w.result_data, rsp_word.result_data);
                  n_errors++;
               end
               if (rsp_word.entries !== exp_w.entries) begin
                  $error("entries: expected %0d, actual %0d",
                         exp_w.entries, rsp_word.entries);
                  n_errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int i, k;
      for (i = 0; i < NIL; i++) begin
         sh_next[i] = 0; sh_prev[i] = 0; sh_data[i] = '0;
         sh_used[i] = 0; sh_written[i] = 0;
      end
      save_shadow();

      // directed: empty list errors, extremes of fields, insert on empty
      plan(pll_pkg::ACT_POP_FRONT, 6'd0, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_PEEK_BACK, 6'd63, 6'd63, '0, 1'b0);
      plan(pll_pkg::ACT_REMOVE, 6'd5, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_MV_AFTER, 6'd1, 6'd2, '0, 1'b0);
      plan(pll_pkg::ACT_INS_AFTER, 6'd63, 6'd0, 32'hFFFF_FFFF, 1'b1);
      plan(pll_pkg::ACT_PUSH_FRONT, 6'd0, 6'd0, 32'h0000_0000, 1'b1);
      plan(pll_pkg::ACT_PUSH_BACK, 6'd0, 6'd0, 32'hA5A5_5A5A, 1'b1);
      plan(pll_pkg::ACT_INS_BEFORE, 6'd1, 6'd0, 32'h1234_5678, 1'b1);
      plan(pll_pkg::ACT_INS_BEFORE, 6'd40, 6'd0, 32'h1, 1'b1);
      plan(pll_pkg::ACT_MV_BEFORE, 6'd2, 6'd2, '0, 1'b0);
      plan(pll_pkg::ACT_MV_BEFORE, 6'd2, 6'd50, '0, 1'b0);
      plan(pll_pkg::ACT_MV_BEFORE, 6'd2, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_MV_AFTER, 6'd1, 6'd2, '0, 1'b0);
      plan(pll_pkg::ACT_PEEK_FRONT, 6'd0, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_PEEK_BACK, 6'd0, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_REMOVE, 6'd3, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_REMOVE, 6'd1, 6'd0, '0, 1'b0);
      plan(pll_pkg::ACT_PUSH_BACK, 6'd0, 6'd0, 32'h5555_AAAA, 1'b0);
      plan(4'd11, 6'd3, 6'd3, 32'hDEAD_BEEF, 1'b1);
      plan(4'd15, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0);
      plan(pll_pkg::ACT_POP_BACK, 6'd0, 6'd0, '0, 1'b0);
      // fill the pool and run into pool full
      for (i = 0; i < 64; i++)
         plan(4'($urandom_range(1)), 6'd0, 6'd0, $urandom, 1'b1);
      plan(pll_pkg::ACT_INS_AFTER, pick_listed(), 6'd0, $urandom, 1'b1);
      plan(pll_pkg::ACT_INS_BEFORE, 6'd0, 6'd0, $urandom, 1'b1);

      // random phases alternating growth and drain
      for (k = 0; k < 10; k++)
         for (i = 0; i < 115; i++)
            plan_random(k % 2);

      restore_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one pause until the engine is drained
      wait (n_sent >= 200);
      hold_sender = 1;
      wait (expected_rsps.size() == 0 && !busy && !start);
      hold_sender = 0;

      wait (pending_cmds.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      $display("checked %0d result words for %0d commands", n_checked, n_sent);
      $display("status mix: ok %0d, empty %0d, full %0d, not found %0d, same %0d",
               stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pll_pkg.sv
hw/rtl/pll_link_mem.sv
hw/rtl/pll_data_mem.sv
hw/rtl/pooled_linked_list_engine_top.sv
tb/pooled_linked_list_engine_top_tb.sv
